FILE: sv/scfb_pkg.sv
// shared types and constants of the servo command frame builder
`timescale 1ns / 1ps

package scfb_pkg;

  // frame layout
  localparam int unsigned MaxBytes  = 11;
  localparam int unsigned MaxBody   = 8;
  localparam int unsigned CntW      = 4;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW     = 1;
  localparam int unsigned QCntW     = 2;

  // protocol bytes
  localparam logic [7:0] HdrByte      = 8'hFF;
  localparam logic [7:0] InsWrite     = 8'h03;
  localparam logic [7:0] InsRegWrite  = 8'h04;
  localparam logic [7:0] InsAction    = 8'h05;
  localparam logic [7:0] AddrLimits   = 8'h06;
  localparam logic [7:0] AddrGoal     = 8'h1E;
  localparam logic [7:0] AddrSpeed    = 8'h20;
  localparam logic [7:0] BroadcastId  = 8'hFE;
  localparam logic [7:0] LenTwoWords  = 8'd7;
  localparam logic [7:0] LenOneWord   = 8'd5;
  localparam logic [7:0] LenNoParams  = 8'd2;
  localparam logic [15:0] ValueMax    = 16'd1023;
  localparam logic [15:0] DirBit      = 16'h0400;

  // body byte counts per frame kind
  localparam logic [CntW-1:0] BodyTwoWords = 4'd8;
  localparam logic [CntW-1:0] BodyOneWord  = 4'd6;
  localparam logic [CntW-1:0] BodyNoParams = 4'd3;

  // request operation codes
  typedef enum logic [2:0] {
    OP_LIMITS     = 3'd0,
    OP_POSITION   = 3'd1,
    OP_REG_POSITION = 3'd2,
    OP_ACTION     = 3'd3,
    OP_SPEED      = 3'd4
  } op_e;

  // one fully built frame, byte 0 goes out first
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
  } frame_t;

  // clamp a 16-bit value to the servo range
  function automatic logic [15:0] clamp_value(input logic [15:0] v);
    clamp_value = (v > ValueMax) ? ValueMax : v;
  endfunction

endpackage

FILE: sv/scfb_front.sv
// front end: takes requests, classifies them and builds the whole frame
`timescale 1ns / 1ps

module scfb_front
  import scfb_pkg::*;
(
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  servo_id_i,
  input  logic [15:0] first_value_i,
  input  logic [15:0] second_value_i,
  output logic        push_o,
  output frame_t      push_frame_o,
  input  logic        queue_full_i
);

  logic [MaxBody-1:0][7:0] body;
  logic [CntW-1:0]         body_cnt;
  logic                    op_ok;
  logic [15:0]             val_a;
  logic [15:0]             val_b;
  logic                    spd_neg;
  logic [15:0]             spd_mag;
  logic [15:0]             spd_word;
  logic [7:0]              sum;
  logic [7:0]              chk;

  // request is taken whenever the queue has room; bad codes are dropped
  assign req_ready_o = !queue_full_i;
  assign push_o      = req_valid_i && req_ready_o && op_ok;

  // signed speed to magnitude plus direction bit
  always_comb begin
    spd_neg  = first_value_i[15];
    spd_mag  = spd_neg ? (~first_value_i + 16'd1) : first_value_i;
    spd_word = clamp_value(spd_mag) | (spd_neg ? DirBit : 16'd0);
  end

  // frame body per operation
  always_comb begin
    body     = '0;
    body_cnt = BodyTwoWords;
    op_ok    = 1'b1;
    val_a    = clamp_value(first_value_i);
    val_b    = clamp_value(second_value_i);
    case (operation_i)
      OP_LIMITS, OP_POSITION, OP_REG_POSITION: begin
        if (operation_i == OP_REG_POSITION) begin
          val_a = first_value_i;
          val_b = second_value_i;
        end
        body[0] = servo_id_i;
        body[1] = LenTwoWords;
        body[2] = (operation_i == OP_REG_POSITION) ? InsRegWrite : InsWrite;
        body[3] = (operation_i == OP_LIMITS) ? AddrLimits : AddrGoal;
        body[4] = val_a[7:0];
        body[5] = val_a[15:8];
        body[6] = val_b[7:0];
        body[7] = val_b[15:8];
      end
      OP_ACTION: begin
        body[0]  = BroadcastId;
        body[1]  = LenNoParams;
        body[2]  = InsAction;
        body_cnt = BodyNoParams;
      end
      OP_SPEED: begin
        body[0]  = servo_id_i;
        body[1]  = LenOneWord;
        body[2]  = InsWrite;
        body[3]  = AddrSpeed;
        body[4]  = spd_word[7:0];
        body[5]  = spd_word[15:8];
        body_cnt = BodyOneWord;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  // checksum over the body, unused slots are zero
  always_comb begin
    sum = '0;
    for (int i = 0; i < MaxBody; i++) begin
      sum = sum + body[i];
    end
    chk = ~sum;
  end

  // header, body and checksum in emit order
  always_comb begin
    push_frame_o.bytes    = '0;
    push_frame_o.bytes[0] = HdrByte;
    push_frame_o.bytes[1] = HdrByte;
    for (int i = 0; i < MaxBody; i++) begin
      push_frame_o.bytes[i + 2] = body[i];
    end
    for (int i = 0; i < MaxBytes; i++) begin
      if (CntW'(i) == body_cnt + CntW'(2)) begin
        push_frame_o.bytes[i] = chk;
      end
    end
    push_frame_o.count = body_cnt + CntW'(3);
  end

endmodule

FILE: sv/scfb_queue.sv
// small frame queue between front and back end
`timescale 1ns / 1ps

module scfb_queue
  import scfb_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t push_frame_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output frame_t pop_frame_o
);

  frame_t            entry_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o      = (cnt_q == QCntW'(QueueDepth));
  assign valid_o     = (cnt_q != '0);
  assign pop_frame_o = entry_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // frame storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_frame_i;
    end
  end

endmodule

FILE: sv/scfb_back.sv
// back end: walks a queued frame and sends it one byte per transfer
`timescale 1ns / 1ps

module scfb_back
  import scfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       queue_valid_i,
  input  frame_t     queue_frame_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       last_byte_o
);

  frame_t          frame_q, frame_d;
  logic            active_q, active_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            ovalid_q, ovalid_d;
  logic [7:0]      obyte_q, obyte_d;
  logic            olast_q, olast_d;
  logic            out_free;
  logic            emit;
  logic            at_last;

  assign out_free = !ovalid_q || out_ready_i;
  assign emit     = active_q && out_free;
  assign at_last  = (idx_q == frame_q.count - CntW'(1));
  // load the next frame while the current last byte goes out
  assign pop_o    = queue_valid_i && (!active_q || (emit && at_last));

  always_comb begin
    frame_d  = frame_q;
    active_d = active_q;
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    // output register drains
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    // next byte into the output register
    if (emit) begin
      ovalid_d = 1'b1;
      obyte_d  = frame_q.bytes[idx_q];
      olast_d  = at_last;
      idx_d    = idx_q + CntW'(1);
      if (at_last) begin
        active_d = 1'b0;
      end
    end
    // frame load
    if (pop_o) begin
      frame_d  = queue_frame_i;
      active_d = 1'b1;
      idx_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign out_valid_o  = ovalid_q;
  assign frame_byte_o = obyte_q;
  assign last_byte_o  = olast_q;

endmodule

FILE: sv/servo_command_frame_builder_top.sv
// top level of the servo command frame builder
`timescale 1ns / 1ps

// Each request on the slave stream becomes one servo bus instruction frame
// sent on the master stream one byte per transfer, tlast on the checksum.
// Limits, position and registered position requests give 11 bytes, a speed
// request 9 and the broadcast action 6; operation codes 5 to 7 are taken and
// dropped. The byte serializer sends one byte per cycle while the master
// stream is ready, with no gap between frames. The front end builds a whole
// frame, checksum included, in the cycle a request is taken and puts it into a
// two-entry queue; requests are refused only while that queue is full. When the
// block is idle, the first byte of a frame passes through the queue, the
// serializer's frame register and its output register.

module servo_command_frame_builder_top
  import scfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[2:0], servo_id[10:3], first_value[26:11], second_value[42:27]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // frame_byte[7:0]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);

  logic   push;
  frame_t push_frame;
  logic   queue_full;
  logic   pop;
  logic   queue_valid;
  frame_t pop_frame;

  // request decode and frame build
  scfb_front u_front (
    .req_valid_i    (s_axis_tvalid),
    .req_ready_o    (s_axis_tready),
    .operation_i    (s_axis_tdata[2:0]),
    .servo_id_i     (s_axis_tdata[10:3]),
    .first_value_i  (s_axis_tdata[26:11]),
    .second_value_i (s_axis_tdata[42:27]),
    .push_o         (push),
    .push_frame_o   (push_frame),
    .queue_full_i   (queue_full)
  );

  // decoupling queue
  scfb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_frame_i (push_frame),
    .full_o       (queue_full),
    .pop_i        (pop),
    .valid_o      (queue_valid),
    .pop_frame_o  (pop_frame)
  );

  // byte serializer
  scfb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_valid_i (queue_valid),
    .queue_frame_i (pop_frame),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .frame_byte_o  (m_axis_tdata),
    .last_byte_o   (m_axis_tlast)
  );

endmodule

FILE: tb/servo_command_frame_builder_checker.sv
// frame byte predictor and checker for the servo command frame builder
`timescale 1ns / 1ps

module servo_command_frame_builder_checker
  import scfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // operation[2:0], servo_id[10:3], first_value[26:11], second_value[42:27]
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // frame_byte[7:0]
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          errors_o,
  output int          pending_o
);

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  // bytes of all requested frames still to come out, oldest first
  frame_byte_t bytes_due[$];

  function automatic logic [15:0] limit_range(input logic [15:0] v);
    limit_range = (v > ValueMax) ? ValueMax : v;
  endfunction

  // build the frame one request asks for and queue its bytes
  task automatic predict_frame(input logic [2:0] op, input logic [7:0] id,
                               input logic [15:0] first_val,
                               input logic [15:0] second_val);
    logic [7:0]  body [9];
    int          n;
    logic [15:0] a;
    logic [15:0] b;
    logic [16:0] mag;
    logic [7:0]  sum;
    frame_byte_t fb;
    n = 0;
    case (op)
      OP_LIMITS, OP_POSITION, OP_REG_POSITION: begin
        // the registered write passes its values through unclamped
        if (op == OP_REG_POSITION) begin
          a = first_val;
          b = second_val;
        end else begin
          a = limit_range(first_val);
          b = limit_range(second_val);
        end
        body[0] = id;
        body[1] = LenTwoWords;
        body[2] = (op == OP_REG_POSITION) ? InsRegWrite : InsWrite;
        body[3] = (op == OP_LIMITS) ? AddrLimits : AddrGoal;
        body[4] = a[7:0];
        body[5] = a[15:8];
        body[6] = b[7:0];
        body[7] = b[15:8];
        n = 8;
      end
      OP_ACTION: begin
        body[0] = BroadcastId;
        body[1] = LenNoParams;
        body[2] = InsAction;
        n = 3;
      end
      OP_SPEED: begin
        // magnitude of the signed speed, clamped, direction in bit 10
        mag = first_val[15] ? (17'h10000 - {1'b0, first_val}) : {1'b0, first_val};
        if (mag > {1'b0, ValueMax}) mag = {1'b0, ValueMax};
        if (first_val[15]) mag[10] = 1'b1;
        body[0] = id;
        body[1] = LenOneWord;
        body[2] = InsWrite;
        body[3] = AddrSpeed;
        body[4] = mag[7:0];
        body[5] = mag[15:8];
        n = 6;
      end
      default: n = 0;
    endcase
    if (n > 0) begin
      fb.data = HdrByte;
      fb.last = 1'b0;
      bytes_due.push_back(fb);
      bytes_due.push_back(fb);
      sum = 8'd0;
      for (int i = 0; i < n; i++) begin
        fb.data = body[i];
        bytes_due.push_back(fb);
        sum = sum + body[i];
      end
      fb.data = ~sum;
      fb.last = 1'b1;
      bytes_due.push_back(fb);
    end
  endtask

  // predict on each request transfer, compare on each byte transfer
  always @(posedge clk_i or negedge rst_ni) begin
    frame_byte_t exp_b;
    if (!rst_ni) begin
      bytes_due.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predict_frame(s_axis_tdata[2:0], s_axis_tdata[10:3],
                      s_axis_tdata[26:11], s_axis_tdata[42:27]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (bytes_due.size() == 0) begin
          $error("unexpected frame_byte transfer: frame_byte 0x%02h last_byte %0b",
                 m_axis_tdata, m_axis_tlast);
          errors_o++;
        end else begin
          exp_b = bytes_due.pop_front();
          if (m_axis_tdata !== exp_b.data) begin
            $error("frame_byte: expected 0x%02h, actual 0x%02h", exp_b.data, m_axis_tdata);
            errors_o++;
          end
          if (m_axis_tlast !== exp_b.last) begin
            $error("last_byte: expected %0b, actual %0b", exp_b.last, m_axis_tlast);
            errors_o++;
          end
        end
      end
      pending_o = bytes_due.size();
    end
  end

endmodule

FILE: tb/servo_command_frame_builder_top_tb.sv
// testbench top: clock, reset, request and byte stream drivers, verdict
`timescale 1ns / 1ps

module servo_command_frame_builder_top_tb;
  import scfb_pkg::*;

  localparam logic [2:0] OpUnused5 = 3'd5;
  localparam logic [2:0] OpUnused6 = 3'd6;
  localparam logic [2:0] OpUnused7 = 3'd7;
  localparam int RandomFrames = 180;
  localparam int CalmAfter    = 150;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  int          errors;
  int          pending;
  logic        calm = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  servo_command_frame_builder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  servo_command_frame_builder_checker frame_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  // one request transfer, then maybe an idle burst
  task automatic send_request(input logic [2:0] op, input logic [7:0] id,
                              input logic [15:0] first_val, input logic [15:0] second_val);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, second_val, first_val, id, op};
    // ready seen at the falling edge holds through the next rising edge
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    if (!calm && $urandom_range(0, 99) < 35) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // values weighted toward the clamp boundary and the extremes
  function automatic logic [15:0] pick_value();
    logic [15:0] v;
    case ($urandom_range(0, 6))
      0: v = 16'($urandom_range(0, 1023));
      1: v = 16'($urandom_range(1000, 1050));
      2: v = 16'(16'hFFFF - $urandom_range(0, 3));
      3: v = 16'(16'h8000 + $urandom_range(0, 3) - 2);
      4: v = 16'(16'h0000 - $urandom_range(1000, 1050));
      default: v = 16'($urandom_range(0, 65535));
    endcase
    return v;
  endfunction

  // byte side: ready runs with random stall bursts, none in the calm part
  initial begin
    @(posedge rst_ni);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!calm) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
  end

  // request side and verdict
  initial begin
    int       frames;
    logic [2:0] op;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, clamp edges, every operation
    send_request(OP_LIMITS, 8'h00, 16'd0, 16'd0);
    send_request(OP_LIMITS, 8'hFF, 16'd1023, 16'd1024);
    send_request(OP_LIMITS, 8'hFE, 16'hFFFF, 16'hFFFF);
    send_request(OP_POSITION, 8'h01, 16'd1024, 16'd1023);
    send_request(OP_POSITION, 8'hFF, 16'hFFFF, 16'h0000);
    send_request(OP_POSITION, 8'h55, 16'd512, 16'd300);
    send_request(OP_REG_POSITION, 8'hAA, 16'hFFFF, 16'hFFFF);
    send_request(OP_REG_POSITION, 8'h00, 16'h1234, 16'h5678);
    send_request(OP_REG_POSITION, 8'hFF, 16'h0000, 16'h8001);
    // action ignores id and values
    send_request(OP_ACTION, 8'h00, 16'h0000, 16'h0000);
    send_request(OP_ACTION, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(OP_SPEED, 8'h10, 16'd0, 16'hFFFF);
    send_request(OP_SPEED, 8'h11, 16'd1023, 16'd0);
    send_request(OP_SPEED, 8'h12, 16'd1024, 16'd0);
    send_request(OP_SPEED, 8'h13, 16'h7FFF, 16'd0);
    send_request(OP_SPEED, 8'h14, 16'hFFFF, 16'd0);
    // most negative speed
    send_request(OP_SPEED, 8'h15, 16'h8000, 16'd0);
    send_request(OP_SPEED, 8'h16, 16'hFC01, 16'd0);
    send_request(OP_SPEED, 8'h17, 16'hFC00, 16'd0);
    // undefined operations give no frame
    send_request(OpUnused5, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(OpUnused6, 8'h00, 16'h0000, 16'h0000);
    send_request(OpUnused7, 8'h5A, 16'hA5A5, 16'h5A5A);
    send_request(OP_LIMITS, 8'h80, 16'd1, 16'd1022);

    // random requests, a few undefined ones mixed in
    frames = 0;
    while (frames < RandomFrames) begin
      if ($urandom_range(0, 99) < 8) begin
        op = 3'($urandom_range(5, 7));
      end else begin
        op = 3'($urandom_range(0, 4));
        frames++;
      end
      if (frames >= CalmAfter) calm = 1'b1;
      send_request(op, 8'($urandom_range(0, 255)), pick_value(), pick_value());
    end
    s_axis_tvalid <= 1'b0;

    // drain, then let any stray bytes show up
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
